// ===== hw/rtl/pcrc_pkg.sv =====
package pcrc_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int KEY_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SQ_SIZE = 25;
  localparam logic [4:0] J_AS_I = 5'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY     = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADCHAR = 2'd1;
  localparam logic [1:0] ST_EVENKEY = 2'd2;
  localparam logic [1:0] ST_TOOLONG = 2'd3;

  localparam logic [7:0] ENG_SQ [SQ_SIZE] = '{
    8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6b,
    8'h6c, 8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75,
    8'h76, 8'h77, 8'h78, 8'h79, 8'h7a
  };
  localparam logic [7:0] MATH_SQ [SQ_SIZE] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h2b, 8'h2d, 8'h3d, 8'h2a, 8'h2f, 8'h28, 8'h29, 8'h20, 8'h2e, 8'h2c,
    8'h21, 8'h3c, 8'h3e, 8'h5b, 8'h5d
  };

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic       found;
    logic [4:0] idx;
  } sq_hit_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_MOD,
    S_SETP,
    S_RD0,
    S_RD,
    S_EMIT,
    S_ERR
  } ctrl_state_e;

  typedef struct packed {
    logic in_acc;
    logic mod_start;
    logic mod_step;
    logic set_ptr;
    logic rd_en;
    logic take_col;
    logic emit;
    logic emit_err;
  } pcrc_cmd_t;

  typedef struct packed {
    logic last_err;
    logic mod_done;
    logic out_free;
    logic emit_last;
  } pcrc_sts_t;

  function automatic sq_hit_t sq_index(input logic [7:0] ch, input logic sel);
    sq_hit_t hit;
    hit.found = 1'b0;
    hit.idx = '0;
    if (!sel && ch == 8'h6a) begin
      hit.found = 1'b1;
      hit.idx = J_AS_I;
    end
    for (int i = 0; i < SQ_SIZE; i++) begin
      if ((sel ? MATH_SQ[i] : ENG_SQ[i]) == ch) begin
        hit.found = 1'b1;
        hit.idx = 5'(i);
      end
    end
    return hit;
  endfunction

  // square index to {row, col}
  function automatic logic [5:0] sq_rc(input logic [4:0] idx);
    logic [2:0] row;
    logic [4:0] col;
    if (idx >= 5'd20)      row = 3'd4;
    else if (idx >= 5'd15) row = 3'd3;
    else if (idx >= 5'd10) row = 3'd2;
    else if (idx >= 5'd5)  row = 3'd1;
    else                   row = 3'd0;
    col = idx - {row, 2'b00} - 5'(row);
    return {row, col[2:0]};
  endfunction

  function automatic logic [7:0] sq_char(input logic sel, input logic [2:0] row,
                                         input logic [2:0] col);
    logic [4:0] idx;
    idx = {row, 2'b00} + 5'(row) + 5'(col);
    if (idx >= 5'(SQ_SIZE)) idx = '0;
    return sel ? MATH_SQ[idx] : ENG_SQ[idx];
  endfunction

endpackage

// ===== hw/rtl/pcrc_ctrl.sv =====
module pcrc_ctrl
  import pcrc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  output logic      in_stall_o,
  input  pcrc_sts_t sts_i,
  output pcrc_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i && in_last_i) begin
          state_d = sts_i.last_err ? S_ERR : S_MOD;
        end
      end
      S_MOD: begin
        if (sts_i.mod_done) state_d = S_SETP;
      end
      S_SETP: state_d = S_RD0;
      S_RD0:  state_d = S_RD;
      S_RD:   state_d = S_EMIT;
      S_EMIT: begin
        if (sts_i.out_free && sts_i.emit_last) state_d = S_LOAD;
      end
      S_ERR: begin
        if (sts_i.out_free) state_d = S_LOAD;
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_LOAD: begin
        in_stall_o = 1'b0;
        cmd_o.in_acc = in_valid_i;
        cmd_o.mod_start = in_valid_i && in_last_i && !sts_i.last_err;
      end
      S_MOD:  cmd_o.mod_step = 1'b1;
      S_SETP: cmd_o.set_ptr = 1'b1;
      S_RD0:  cmd_o.rd_en = 1'b1;
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.take_col = 1'b1;
      end
      S_EMIT: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.rd_en = sts_i.out_free && !sts_i.emit_last;
      end
      S_ERR:  cmd_o.emit_err = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== hw/rtl/pcrc_dp.sv =====
module pcrc_dp
  import pcrc_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  in_item_t             in_item_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [KEY_W-1:0]     cfg_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output out_item_t            out_item_o,
  input  pcrc_cmd_t            cmd_i,
  output pcrc_sts_t            sts_o
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int NW = KEY_W - 1;
  localparam int SW = $clog2(NW);

  // configuration
  logic             decrypt_q, alpha_q;
  logic [KEY_W-1:0] key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q <= 1'b0;
      alpha_q   <= 1'b0;
      key_q     <= KEY_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DECRYPT: decrypt_q <= cfg_data_i[0];
        CFG_ALPHA:   alpha_q   <= cfg_data_i[0];
        CFG_KEY:     key_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // message load
  logic [CW-1:0] count_q, count_d;
  logic          bad_q, bad_d, ovf_q, ovf_d;
  logic [1:0]    code_q, code;
  logic [CW-1:0] n_q;
  sq_hit_t       hit;
  logic          store_ok, bad_all, ovf_all, wr_en;
  logic [5:0]    wr_rc;

  assign hit      = sq_index(in_item_i.in_char, alpha_q);
  assign store_ok = count_q < CW'(MAX_LEN);
  assign bad_all  = bad_q | (store_ok & !hit.found);
  assign ovf_all  = ovf_q | !store_ok;
  assign wr_en    = cmd_i.in_acc && store_ok;
  // a character outside the square is kept as row 0, col 0
  assign wr_rc    = hit.found ? sq_rc(hit.idx) : 6'd0;

  always_comb begin
    if (!key_q[0])    code = ST_EVENKEY;
    else if (bad_all) code = ST_BADCHAR;
    else if (ovf_all) code = ST_TOOLONG;
    else              code = ST_OK;
  end

  always_comb begin
    count_d = count_q;
    bad_d   = bad_q;
    ovf_d   = ovf_q;
    if (cmd_i.in_acc) begin
      if (in_item_i.in_last) begin
        count_d = '0;
        bad_d   = 1'b0;
        ovf_d   = 1'b0;
      end else begin
        count_d = store_ok ? count_q + 1'b1 : count_q;
        bad_d   = bad_all;
        ovf_d   = ovf_all;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      bad_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      bad_q   <= bad_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_acc && in_item_i.in_last) begin
      code_q <= code;
      n_q    <= count_q + 1'b1;
    end
  end

  // coordinate memory, one {row, col} entry per character
  logic [5:0]    mem [MAX_LEN];
  logic [5:0]    rd_q;
  logic [AW-1:0] ptr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[count_q[AW-1:0]] <= wr_rc;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rd_q <= mem[ptr_q];
  end

  // key reduction: (key >> 1) mod n, one quotient bit per cycle
  logic [CW-1:0] rem_q;
  logic [NW-1:0] kbits_q;
  logic [SW-1:0] step_q;
  logic [CW:0]   trial;

  assign trial = {rem_q, kbits_q[NW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_start) begin
      rem_q   <= '0;
      kbits_q <= key_q[KEY_W-1:1];
      step_q  <= '0;
    end else if (cmd_i.mod_step) begin
      rem_q   <= (trial >= {1'b0, n_q}) ? CW'(trial - {1'b0, n_q}) : trial[CW-1:0];
      kbits_q <= kbits_q << 1;
      step_q  <= step_q + 1'b1;
    end
  end

  // with an odd key every output pairs the column of one character with the
  // row of the next, so the walk starts at the character holding the first column
  logic [CW-1:0] remain_q;
  logic [2:0]    col_q;
  logic [CW-1:0] p0;
  logic [AW-1:0] ptr_next;

  assign p0       = decrypt_q ? n_q - 1'b1 - rem_q : rem_q;
  assign ptr_next = (CW'(ptr_q) == n_q - 1'b1) ? '0 : AW'(ptr_q + 1'b1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_ptr) begin
      ptr_q    <= p0[AW-1:0];
      remain_q <= n_q;
    end else begin
      if (cmd_i.rd_en) ptr_q <= ptr_next;
      if (cmd_i.emit) remain_q <= remain_q - 1'b1;
    end
    if (cmd_i.take_col || cmd_i.emit) col_q <= rd_q[2:0];
  end

  // output register
  logic      out_valid_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_err) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // stored column becomes the new row, the next character's row the new column
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.out_char <= sq_char(alpha_q, col_q, rd_q[5:3]);
      out_q.out_last <= remain_q == CW'(1);
      out_q.status   <= ST_OK;
    end else if (cmd_i.emit_err) begin
      out_q.out_char <= '0;
      out_q.out_last <= 1'b1;
      out_q.status   <= code_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign sts_o.last_err  = code != ST_OK;
  assign sts_o.mod_done  = step_q == SW'(NW - 1);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.emit_last = remain_q == CW'(1);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_LEN))
    else $error("character count beyond maximum length");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mod_step |-> rem_q < n_q)
    else $error("key remainder not below message length");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> CW'(ptr_q) < n_q)
    else $error("coordinate read outside the message");

  a_emit_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> remain_q != '0)
    else $error("result emitted past the end of the message");

  a_emit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_err |-> !cmd_i.emit && !cmd_i.rd_en)
    else $error("error result overlaps normal emit");

endmodule

// ===== hw/rtl/polybius_coordinate_rotation_cipher.sv =====
// Polybius coordinate rotation cipher. Characters load one per cycle while
// in_stall_o is low; each maps through the selected 5x5 square to a row and
// column kept in a coordinate memory of MAX_LEN entries. After the item marked
// last the block stalls its input: a bit-serial divider reduces key >> 1
// modulo the message length, the states S_SETP, S_RD0 and S_RD set up the read
// walk, then one result leaves per cycle while the output is not stalled (the
// memory read port sets that pace). An error message (even key, bad character,
// too long) gives one result from the S_ERR state once the output register is
// free. The output register lets the next message start loading while the
// final result still waits. Registers: 0 decrypt mode, 1 alphabet select, 2
// shift key; write them only while the block is idle.
module polybius_coordinate_rotation_cipher
  import pcrc_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [KEY_W-1:0]     cfg_data_i
);

  pcrc_cmd_t cmd;
  pcrc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  pcrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_item_i.in_last),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcrc_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
